/* rtl/core/brvt_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket range validity table package
// Sizes, request codes and the span type shared by the table's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package brvt_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int ADDR_W = $clog2(2 * DEPTH);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int NODE_W = IDX_W + 2;
    localparam int POS_W  = 10;
    localparam int REND_W = 11;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic signed [NODE_W-1:0] sum;
        logic signed [NODE_W-1:0] lo;
    } span_t;

    localparam int SPAN_W = $bits(span_t);

endpackage

`default_nettype wire

/* rtl/core/brvt_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/brvt_join.sv */
// ----------------------------------------------------------------------------
// Span join unit
// Combines two bracket spans: total sum and lowest running prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module brvt_join (
    input  wire brvt_pkg::span_t a,
    input  wire logic            a_none,
    input  wire brvt_pkg::span_t b,
    input  wire logic            b_none,
    output brvt_pkg::span_t      r
);

    logic signed [brvt_pkg::NODE_W-1:0] shifted;

    assign shifted = a.sum + b.lo;

    always_comb
    begin
        if (a_none)
        begin
            r = b;
        end
        else if (b_none)
        begin
            r = a;
        end
        else
        begin
            r.sum = a.sum + b.sum;
            r.lo  = (a.lo < shifted) ? a.lo : shifted;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bracket_range_validity_table.sv */
// ----------------------------------------------------------------------------
// Bracket range validity table
// Segment tree over a bracket string; write, read and range validity requests
// run through one tree memory and one shared span join unit.
// ----------------------------------------------------------------------------
// Read: the leaf is read on acceptance, its bracket taken in ST_R_WAIT and
// the result set in ST_FIN. Write: the leaf is written on acceptance, then
// one sibling read and one parent write per tree level. Query: one memory
// read per visited node. One request at a time; the result register lets the
// next request enter. After reset a clearing pass loads the tree with all
// open brackets; s_tready stays low until it ends.
`default_nettype none

module bracket_range_validity_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // position[9:0], right_end[20:10], bracket_in[21]
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // range_valid[0], bracket_out[1], status[2]
);

    localparam int AW = brvt_pkg::ADDR_W;
    localparam int PW = brvt_pkg::PTR_W;
    localparam int NW = brvt_pkg::NODE_W;
    localparam int REND_W1 = brvt_pkg::REND_W + 1;

    function automatic logic IDX_OK(input logic [brvt_pkg::POS_W-1:0] idx);
        IDX_OK = (REND_W1'(idx) < REND_W1'(brvt_pkg::DEPTH));
    endfunction

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_TEST,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_END,
        ST_W_READ,
        ST_W_JOIN,
        ST_R_WAIT,
        ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   l_reg, l_next, r_reg, r_next;
    brvt_pkg::span_t left_reg, left_next, right_reg, right_next, cur_reg, cur_next;
    logic            left_none_reg, left_none_next, right_none_reg, right_none_next;
    logic [AW-1:0]   node_reg, node_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [NW-1:0]   clr_span_reg, clr_span_next;
    logic            res_valid_reg, res_valid_next;
    logic            res_bout_reg, res_bout_next;
    logic            res_status_reg, res_status_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [2:0]      m_fields_reg, m_fields_next;

    logic [1:0]                  req_type;
    logic [brvt_pkg::POS_W-1:0]  position;
    logic [brvt_pkg::REND_W-1:0] right_end;
    logic                        bracket_in;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    brvt_pkg::span_t             ram_wdata, ram_rdata;
    logic [brvt_pkg::SPAN_W-1:0] ram_rdata_raw;

    brvt_pkg::span_t join_a, join_b, join_r;
    logic            join_a_none, join_b_none;

    logic [AW-1:0]   leaf_addr;
    logic [PW-1:0]   l_inc, r_dec;
    logic [AW-1:0]   parent;
    logic [AW-1:0]   clr_idx_inc;
    brvt_pkg::span_t leaf_span;

    assign req_type   = s_tuser[1:0];
    assign position   = s_tdata[9:0];
    assign right_end  = s_tdata[20:10];
    assign bracket_in = s_tdata[21];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_fields_reg};

    assign ram_rdata   = brvt_pkg::span_t'(ram_rdata_raw);
    assign leaf_addr   = AW'(brvt_pkg::DEPTH) + AW'(position);
    assign l_inc       = l_reg + PW'(1);
    assign r_dec       = r_reg - PW'(1);
    assign parent      = node_reg >> 1;
    assign clr_idx_inc = clr_idx_reg + AW'(1);
    assign leaf_span.sum = bracket_in ? -NW'(1) : NW'(1);
    assign leaf_span.lo  = bracket_in ? -NW'(1) : NW'(1);

    brvt_ram #(
        .WIDTH(brvt_pkg::SPAN_W),
        .DEPTH(2 * brvt_pkg::DEPTH)
    ) u_tree (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    brvt_join u_join (
        .a     (join_a),
        .a_none(join_a_none),
        .b     (join_b),
        .b_none(join_b_none),
        .r     (join_r)
    );

    always_comb
    begin
        case (state_reg)
            ST_Q_LEFT:
            begin
                join_a      = left_reg;
                join_a_none = left_none_reg;
                join_b      = ram_rdata;
                join_b_none = 1'b0;
            end
            ST_Q_RIGHT:
            begin
                join_a      = ram_rdata;
                join_a_none = 1'b0;
                join_b      = right_reg;
                join_b_none = right_none_reg;
            end
            ST_W_JOIN:
            begin
                join_a      = node_reg[0] ? ram_rdata : cur_reg;
                join_a_none = 1'b0;
                join_b      = node_reg[0] ? cur_reg : ram_rdata;
                join_b_none = 1'b0;
            end
            default:
            begin
                join_a      = left_reg;
                join_a_none = left_none_reg;
                join_b      = right_reg;
                join_b_none = right_none_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        cur_next        = cur_reg;
        left_none_next  = left_none_reg;
        right_none_next = right_none_reg;
        node_next       = node_reg;
        clr_idx_next    = clr_idx_reg;
        clr_span_next   = clr_span_reg;
        res_valid_next  = res_valid_reg;
        res_bout_next   = res_bout_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_fields_next   = m_fields_reg;
        ram_we          = 1'b0;
        ram_waddr       = node_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = l_reg[AW-1:0];

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_idx_reg;
                ram_wdata.sum = clr_span_reg;
                ram_wdata.lo  = NW'(1);
                clr_idx_next  = clr_idx_inc;
                if ((clr_idx_inc & clr_idx_reg) == '0)
                begin
                    clr_span_next = clr_span_reg >> 1;
                end
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_valid_next  = 1'b0;
                    res_bout_next   = 1'b0;
                    res_status_next = 1'b0;
                    state_next      = ST_FIN;
                    case (req_type)
                        brvt_pkg::REQ_WRITE:
                        begin
                            if (IDX_OK(position))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = leaf_addr;
                                ram_wdata  = leaf_span;
                                cur_next   = leaf_span;
                                node_next  = leaf_addr;
                                state_next = ST_W_READ;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        brvt_pkg::REQ_QUERY:
                        begin
                            if ((REND_W1'(position) <= REND_W1'(right_end)) &&
                                (REND_W1'(right_end) <= REND_W1'(brvt_pkg::DEPTH)))
                            begin
                                l_next          = PW'(brvt_pkg::DEPTH) + PW'(position);
                                r_next          = PW'(brvt_pkg::DEPTH) + PW'(right_end);
                                left_none_next  = 1'b1;
                                right_none_next = 1'b1;
                                state_next      = ST_Q_TEST;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        brvt_pkg::REQ_READ:
                        begin
                            if (IDX_OK(position))
                            begin
                                ram_raddr  = leaf_addr;
                                state_next = ST_R_WAIT;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_R_WAIT:
            begin
                res_bout_next = ram_rdata.sum[NW-1];
                state_next    = ST_FIN;
            end
            ST_W_READ:
            begin
                ram_raddr  = node_reg ^ AW'(1);
                state_next = ST_W_JOIN;
            end
            ST_W_JOIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = join_r;
                cur_next  = join_r;
                node_next = parent;
                if (parent == AW'(1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_W_READ;
                end
            end
            ST_Q_TEST:
            begin
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        ram_raddr  = l_reg[AW-1:0];
                        state_next = ST_Q_LEFT;
                    end
                    else if (r_reg[0])
                    begin
                        ram_raddr  = r_dec[AW-1:0];
                        state_next = ST_Q_RIGHT;
                    end
                    else
                    begin
                        l_next = l_reg >> 1;
                        r_next = r_reg >> 1;
                    end
                end
                else
                begin
                    state_next = ST_Q_END;
                end
            end
            ST_Q_LEFT:
            begin
                left_next      = join_r;
                left_none_next = 1'b0;
                if (r_reg[0])
                begin
                    l_next     = l_inc;
                    ram_raddr  = r_dec[AW-1:0];
                    state_next = ST_Q_RIGHT;
                end
                else
                begin
                    l_next     = l_inc >> 1;
                    r_next     = r_reg >> 1;
                    state_next = ST_Q_TEST;
                end
            end
            ST_Q_RIGHT:
            begin
                right_next      = join_r;
                right_none_next = 1'b0;
                l_next          = l_reg >> 1;
                r_next          = r_dec >> 1;
                state_next      = ST_Q_TEST;
            end
            ST_Q_END:
            begin
                res_valid_next = (left_none_reg && right_none_reg) ||
                                 ((join_r.sum == '0) && !join_r.lo[NW-1]);
                state_next     = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_fields_next = {res_status_reg, res_bout_reg, res_valid_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= AW'(1);
            clr_span_reg    <= NW'(brvt_pkg::DEPTH);
            m_tvalid_reg    <= 1'b0;
            left_none_reg   <= 1'b1;
            right_none_reg  <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            clr_span_reg    <= clr_span_next;
            m_tvalid_reg    <= m_tvalid_next;
            left_none_reg   <= left_none_next;
            right_none_reg  <= right_none_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg          <= l_next;
        r_reg          <= r_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        cur_reg        <= cur_next;
        node_reg       <= node_next;
        res_valid_reg  <= res_valid_next;
        res_bout_reg   <= res_bout_next;
        res_status_reg <= res_status_next;
        m_fields_reg   <= m_fields_next;
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    a_no_root_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != ST_CLEAR)) |-> (ram_waddr != '0))
        else $error("tree write to unused node zero");

    a_left_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_LEFT) |-> ($past(ram_raddr) == l_reg[AW-1:0]))
        else $error("left node data does not match left pointer");

    a_update_ends_at_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_READ) |-> (node_reg > AW'(1)))
        else $error("tree update walked past the root");
`endif

endmodule

`default_nettype wire
